// ===== hw/rtl/ecor_pkg.sv =====
package ecor_pkg;

  // default chain length
  localparam int NUM_EFFECTS_DEF = 8;

  // depth of the command queue between front and back
  localparam int CMD_QUEUE_DEPTH = 2;

  // command codes, equal to the func field encoding
  typedef enum logic [2:0] {
    OP_REPORT     = 3'd0,
    OP_MOVE_UP    = 3'd1,
    OP_MOVE_DOWN  = 3'd2,
    OP_SET_ENABLE = 3'd3,
    OP_ELEMENT    = 3'd4
  } cmd_op_t;

  // result kinds
  localparam logic [2:0] KIND_ORDER  = 3'd0;
  localparam logic [2:0] KIND_INPUT  = 3'd1;
  localparam logic [2:0] KIND_LINK   = 3'd2;
  localparam logic [2:0] KIND_OUTPUT = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  // load check error codes
  localparam logic [1:0] ERR_COUNT = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_DUP   = 2'd2;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] value;
    logic       enable;
    logic       last_elem;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] slot;
    logic [2:0] effect_id;
    logic [2:0] link_target;
    logic       found;
    logic [1:0] error_code;
    logic       last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_CHECK,
    S_ERR,
    S_ORDER,
    S_ROUTE,
    S_ROUTE_END,
    S_ROUTE_OUT
  } back_state_t;

endpackage

// ===== hw/rtl/effect_chain_order_router.sv =====
// Effect chain order router.
//
// Input channel (push/full): one command per transfer, fields func,
// effect_value, enable_flag, last_element. Commands land in a two-entry
// queue, so the sender keeps going while the back end is busy; unknown
// func codes are taken and dropped there.
// Result channel (empty/pop): a result is on the ports while empty is low
// and leaves on a transfer with pop high. last marks the final result of
// a command. A held result never stops the back end from preparing the
// next one; it stalls only when that one has nowhere to go.
// Sequence: the back end walks the chain one slot per cycle unless a result
// it must emit has nowhere to go. Report: take the command, emit the order,
// scan for the routing, emit the ends. A move adds a search first; a good
// load adds a check, a bad one ends early with a single error result.
// With the back end idle, a report's command passes through the queue and
// the order state before its first result is registered.
// Reset (rst, synchronous): identity order, all effects disabled, load
// count cleared, command queue and result register empty. No clearing pass is needed.
module effect_chain_order_router #(
  parameter int NUM_EFFECTS = ecor_pkg::NUM_EFFECTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [2:0] func,
  input  logic [7:0] effect_value,
  input  logic       enable_flag,
  input  logic       last_element,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] kind,
  output logic [2:0] slot,
  output logic [2:0] effect_id,
  output logic [2:0] link_target,
  output logic       found,
  output logic [1:0] error_code,
  output logic       last
);
  import ecor_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;
  res_t res;
  logic res_valid;

  // front end: classify and queue commands
  ecor_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .func         (func),
    .effect_value (effect_value),
    .enable_flag  (enable_flag),
    .last_element (last_element),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_take     (cmd_take)
  );

  // back end: owns the chain state and sequences the results
  ecor_back #(
    .NUM_EFFECTS (NUM_EFFECTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .res       (res),
    .res_valid (res_valid),
    .pop       (pop)
  );

  assign empty       = !res_valid;
  assign kind        = res.kind;
  assign slot        = res.slot;
  assign effect_id   = res.effect_id;
  assign link_target = res.link_target;
  assign found       = res.found;
  assign error_code  = res.error_code;
  assign last        = res.last;

  // a load error is always a command's only and final result
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_ERROR) |-> (last && error_code != 2'd3))
    else $error("load error result without last");

  // a missing chain end reports effect 0
  a_notfound_id: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind == KIND_INPUT || kind == KIND_OUTPUT) && !found) |-> (effect_id == 3'd0))
    else $error("chain end not found but effect id nonzero");

  // links sit between chain input and chain output, never final
  a_link_mid: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_LINK) |-> (!last && !found))
    else $error("link result marked last or found");

  // the back end takes a queued command only when one is waiting
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");

endmodule

// ===== hw/rtl/ecor_front.sv =====
module ecor_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [2:0]    func,
  input  logic [7:0]    effect_value,
  input  logic          enable_flag,
  input  logic          last_element,
  output ecor_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_take
);
  import ecor_pkg::*;

  localparam int QD  = CMD_QUEUE_DEPTH;
  localparam int PW  = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNW = $clog2(QD + 1);
  localparam logic [PW-1:0]  PTR_LAST = PW'(QD - 1);
  localparam logic [CNW-1:0] CNT_FULL = CNW'(QD);

  cmd_t           queue [QD];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CNW-1:0] count;
  logic           known;
  logic           wr_en;
  logic           rd_en;
  cmd_t           dec;

  // classify: unknown funcs are taken and dropped
  always_comb begin
    case (func)
      OP_REPORT, OP_MOVE_UP, OP_MOVE_DOWN, OP_SET_ENABLE, OP_ELEMENT: known = 1'b1;
      default: known = 1'b0;
    endcase
    dec.op        = cmd_op_t'(func);
    dec.value     = effect_value;
    dec.enable    = enable_flag;
    dec.last_elem = last_element;
  end

  assign full      = (count == CNT_FULL);
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];
  assign wr_en     = push && !full && known;
  assign rd_en     = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/ecor_back.sv =====
module ecor_back #(
  parameter int NUM_EFFECTS = ecor_pkg::NUM_EFFECTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ecor_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_take,
  output ecor_pkg::res_t res,
  output logic           res_valid,
  input  logic           pop
);
  import ecor_pkg::*;

  localparam int IDW = $clog2(NUM_EFFECTS);
  localparam int CW  = $clog2(NUM_EFFECTS + 2);
  localparam logic [IDW-1:0] LAST_SLOT = IDW'(NUM_EFFECTS - 1);
  localparam logic [CW-1:0]  CNT_N     = CW'(NUM_EFFECTS);
  localparam logic [CW-1:0]  CNT_SAT   = CW'(NUM_EFFECTS + 1);
  localparam logic [7:0]     N8        = 8'(NUM_EFFECTS);

  back_state_t    state, state_next;
  logic [IDW-1:0] order [NUM_EFFECTS];
  logic [IDW-1:0] order_next [NUM_EFFECTS];
  logic [7:0]     lbuf [NUM_EFFECTS];
  logic [7:0]     lbuf_next [NUM_EFFECTS];
  logic [NUM_EFFECTS-1:0] en_mask, en_mask_next;
  logic [CW-1:0]  lcount, lcount_next, lcount_inc;
  logic [IDW-1:0] cnt, cnt_next;
  cmd_t           cur, cur_next;
  logic           have, have_next;
  logic [IDW-1:0] prev_id, prev_id_next;
  logic [1:0]     err, err_next;
  logic           can_emit;
  logic           emit;
  res_t           res_d;
  logic           slot_on;
  logic           dup;

  assign can_emit = !res_valid || pop;
  assign slot_on  = en_mask[order[cnt]];

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < NUM_EFFECTS; j++) begin
      dup = dup | ((IDW'(j) != cnt) && (lbuf[j] == lbuf[cnt]));
    end
  end

  assign lcount_inc = (lcount < CNT_SAT) ? lcount + 1'b1 : lcount;

  always_comb begin
    state_next   = state;
    order_next   = order;
    lbuf_next    = lbuf;
    en_mask_next = en_mask;
    lcount_next  = lcount;
    cnt_next     = cnt;
    cur_next     = cur;
    have_next    = have;
    prev_id_next = prev_id;
    err_next     = err;
    cmd_take     = 1'b0;
    emit         = 1'b0;
    res_d        = '0;

    case (state)
      S_IDLE: begin
        cmd_take = cmd_valid;
        if (cmd_valid) begin
          cur_next  = cmd;
          cnt_next  = '0;
          have_next = 1'b0;
          case (cmd.op)
            OP_REPORT: state_next = S_ORDER;
            OP_MOVE_UP, OP_MOVE_DOWN: state_next = S_FIND;
            OP_SET_ENABLE: begin
              if (cmd.value < N8) begin
                en_mask_next[cmd.value[IDW-1:0]] = cmd.enable;
              end
              state_next = S_ROUTE;
            end
            OP_ELEMENT: begin
              if (lcount < CNT_N) begin
                lbuf_next[lcount[IDW-1:0]] = cmd.value;
              end
              lcount_next = lcount_inc;
              if (cmd.last_elem) begin
                lcount_next = '0;
                if (lcount_inc != CNT_N) begin
                  err_next   = ERR_COUNT;
                  state_next = S_ERR;
                end else begin
                  state_next = S_CHECK;
                end
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      // search for the effect, swap with its neighbor if one exists
      S_FIND: begin
        if (8'(order[cnt]) == cur.value) begin
          if (cur.op == OP_MOVE_UP && cnt != '0) begin
            order_next[cnt - 1'b1] = order[cnt];
            order_next[cnt]        = order[cnt - 1'b1];
          end else if (cur.op == OP_MOVE_DOWN && cnt != LAST_SLOT) begin
            order_next[cnt + 1'b1] = order[cnt];
            order_next[cnt]        = order[cnt + 1'b1];
          end
          cnt_next   = '0;
          state_next = S_ORDER;
        end else if (cnt == LAST_SLOT) begin
          cnt_next   = '0;
          state_next = S_ORDER;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      // one element per cycle; first bad element decides
      S_CHECK: begin
        if (lbuf[cnt] >= N8) begin
          err_next   = ERR_RANGE;
          state_next = S_ERR;
        end else if (dup) begin
          err_next   = ERR_DUP;
          state_next = S_ERR;
        end else if (cnt == LAST_SLOT) begin
          for (int i = 0; i < NUM_EFFECTS; i++) begin
            order_next[i] = lbuf[i][IDW-1:0];
          end
          cnt_next   = '0;
          state_next = S_ORDER;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      S_ERR: begin
        if (can_emit) begin
          emit             = 1'b1;
          res_d.kind       = KIND_ERROR;
          res_d.error_code = err;
          res_d.last       = 1'b1;
          state_next       = S_IDLE;
        end
      end

      S_ORDER: begin
        if (can_emit) begin
          emit            = 1'b1;
          res_d.kind      = KIND_ORDER;
          res_d.slot      = 3'(cnt);
          res_d.effect_id = 3'(order[cnt]);
          if (cnt == LAST_SLOT) begin
            cnt_next   = '0;
            have_next  = 1'b0;
            state_next = S_ROUTE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end

      // walk the chain, emit input on first enabled slot, links after
      S_ROUTE: begin
        if (!slot_on || can_emit) begin
          if (slot_on) begin
            emit         = 1'b1;
            have_next    = 1'b1;
            prev_id_next = order[cnt];
            if (have) begin
              res_d.kind        = KIND_LINK;
              res_d.effect_id   = 3'(prev_id);
              res_d.link_target = 3'(order[cnt]);
            end else begin
              res_d.kind      = KIND_INPUT;
              res_d.effect_id = 3'(order[cnt]);
              res_d.found     = 1'b1;
            end
          end
          if (cnt == LAST_SLOT) begin
            state_next = S_ROUTE_END;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end

      S_ROUTE_END: begin
        if (have) begin
          state_next = S_ROUTE_OUT;
        end else if (can_emit) begin
          emit       = 1'b1;
          res_d.kind = KIND_INPUT;
          state_next = S_ROUTE_OUT;
        end
      end

      S_ROUTE_OUT: begin
        if (can_emit) begin
          emit            = 1'b1;
          res_d.kind      = KIND_OUTPUT;
          res_d.found     = have;
          res_d.effect_id = have ? 3'(prev_id) : 3'd0;
          res_d.last      = 1'b1;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      en_mask   <= '0;
      lcount    <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < NUM_EFFECTS; i++) begin
        order[i] <= IDW'(i);
      end
    end else begin
      state   <= state_next;
      en_mask <= en_mask_next;
      lcount  <= lcount_next;
      order   <= order_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lbuf    <= lbuf_next;
    cnt     <= cnt_next;
    cur     <= cur_next;
    have    <= have_next;
    prev_id <= prev_id_next;
    err     <= err_next;
    if (emit) begin
      res <= res_d;
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ecor_pkg::*;

  localparam int NE = NUM_EFFECTS_DEF;
  // func has 3 bits; codes above OP_ELEMENT are unused and must be dropped
  localparam int FUNC_CODES = 8;
  // cycles with no transfer on either side before the run is called hung
  localparam int HANG_LIMIT = 2000;

  // Tracks the chain order, the enable bits and any load in progress, and
  // keeps the results still owed by the block, oldest first.
  class chain_board;
    logic [2:0] order_tbl[NE];
    bit         en_mask[NE];
    logic [7:0] load_buf[NE];
    int         load_cnt;
    res_t       due_results[$];
    int         errors;
    int         n_checked;
    int         n_good_loads;
    int         n_bad_loads;

    function new();
      for (int i = 0; i < NE; i++) begin
        order_tbl[i] = i[2:0];
        en_mask[i] = 1'b0;
        load_buf[i] = 8'd0;
      end
      load_cnt = 0;
      errors = 0;
      n_checked = 0;
      n_good_loads = 0;
      n_bad_loads = 0;
    endfunction

    function void add_result(logic [2:0] k, logic [2:0] s, logic [2:0] id,
                             logic [2:0] tgt, logic f, logic [1:0] err);
      res_t r;
      r.kind = k;
      r.slot = s;
      r.effect_id = id;
      r.link_target = tgt;
      r.found = f;
      r.error_code = err;
      r.last = 1'b0;
      due_results.push_back(r);
    endfunction

    function void add_order();
      for (int i = 0; i < NE; i++)
        add_result(KIND_ORDER, i[2:0], order_tbl[i], 3'd0, 1'b0, ERR_COUNT);
    endfunction

    // chain input, links between neighbouring enabled effects, chain output
    function void add_routing();
      int on_slots[$];
      int n;
      for (int i = 0; i < NE; i++)
        if (en_mask[order_tbl[i]]) on_slots.push_back(i);
      n = on_slots.size();
      if (n == 0) begin
        add_result(KIND_INPUT, 3'd0, 3'd0, 3'd0, 1'b0, ERR_COUNT);
        add_result(KIND_OUTPUT, 3'd0, 3'd0, 3'd0, 1'b0, ERR_COUNT);
      end else begin
        add_result(KIND_INPUT, 3'd0, order_tbl[on_slots[0]], 3'd0, 1'b1, ERR_COUNT);
        for (int k = 0; k + 1 < n; k++)
          add_result(KIND_LINK, 3'd0, order_tbl[on_slots[k]],
                     order_tbl[on_slots[k + 1]], 1'b0, ERR_COUNT);
        add_result(KIND_OUTPUT, 3'd0, order_tbl[on_slots[n - 1]], 3'd0, 1'b1,
                   ERR_COUNT);
      end
    endfunction

    function int find_slot(logic [7:0] val);
      for (int i = 0; i < NE; i++)
        if (8'(order_tbl[i]) == val) return i;
      return -1;
    endfunction

    // -1 for a clean load, else the error code of the first bad element
    function int load_fault();
      if (load_cnt != NE) return ERR_COUNT;
      for (int i = 0; i < NE; i++) begin
        if (load_buf[i] >= NE) return ERR_RANGE;
        for (int j = 0; j < NE; j++)
          if (j != i && load_buf[j] == load_buf[i]) return ERR_DUP;
      end
      return -1;
    endfunction

    function void note_command(logic [2:0] fn, logic [7:0] val, logic en,
                               logic lst);
      int base;
      int s;
      int fault;
      logic [2:0] t;
      base = due_results.size();
      case (fn)
        OP_REPORT: begin
          add_order();
          add_routing();
        end
        OP_MOVE_UP: begin
          s = find_slot(val);
          if (s > 0) begin
            t = order_tbl[s - 1];
            order_tbl[s - 1] = order_tbl[s];
            order_tbl[s] = t;
          end
          add_order();
          add_routing();
        end
        OP_MOVE_DOWN: begin
          s = find_slot(val);
          if (s >= 0 && s < NE - 1) begin
            t = order_tbl[s + 1];
            order_tbl[s + 1] = order_tbl[s];
            order_tbl[s] = t;
          end
          add_order();
          add_routing();
        end
        OP_SET_ENABLE: begin
          if (val < NE) en_mask[val] = en;
          add_routing();
        end
        OP_ELEMENT: begin
          if (load_cnt < NE) load_buf[load_cnt] = val;
          if (load_cnt < NE + 1) load_cnt++;
          if (lst) begin
            fault = load_fault();
            load_cnt = 0;
            if (fault >= 0) begin
              n_bad_loads++;
              add_result(KIND_ERROR, 3'd0, 3'd0, 3'd0, 1'b0, fault[1:0]);
            end else begin
              n_good_loads++;
              for (int i = 0; i < NE; i++) order_tbl[i] = load_buf[i][2:0];
              add_order();
              add_routing();
            end
          end
        end
        default: ;
      endcase
      if (due_results.size() > base)
        due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    function void cmp(string field, int exp_v, int act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field,
                 exp_v, act_v);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      n_checked++;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, got);
      end else begin
        want = due_results.pop_front();
        cmp("kind", want.kind, got.kind);
        cmp("slot", want.slot, got.slot);
        cmp("effect_id", want.effect_id, got.effect_id);
        cmp("link_target", want.link_target, got.link_target);
        cmp("found", want.found, got.found);
        cmp("error_code", want.error_code, got.error_code);
        cmp("last", want.last, got.last);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [2:0] func = 3'd0;
  logic [7:0] effect_value = 8'd0;
  logic       enable_flag = 1'b0;
  logic       last_element = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [2:0] kind;
  logic [2:0] slot;
  logic [2:0] effect_id;
  logic [2:0] link_target;
  logic       found;
  logic [1:0] error_code;
  logic       last;

  chain_board board = new();

  // no-idle stretches: when set, that side never waits between transfers
  bit tx_eager = 1'b0;
  bit rx_eager = 1'b0;
  int n_cmds = 0;
  int idle_cycles = 0;

  effect_chain_order_router #(.NUM_EFFECTS(NE)) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .func(func),
    .effect_value(effect_value),
    .enable_flag(enable_flag),
    .last_element(last_element),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .slot(slot),
    .effect_id(effect_id),
    .link_target(link_target),
    .found(found),
    .error_code(error_code),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hang detector: any cycle with a transfer on either side resets it.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // One command transfer. push is only lowered when a gap is drawn, so back
  // to back commands keep it high with a single assignment per edge.
  // Handshake signals are read right at the edge, before the block updates.
  task automatic issue_cmd(input logic [2:0] fn, input logic [7:0] val,
                           input logic en, input logic lst);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    func <= fn;
    effect_value <= val;
    enable_flag <= en;
    last_element <= lst;
    do @(posedge clk); while (full);
    board.note_command(fn, val, en, lst);
    n_cmds++;
  endtask

  // Result side, runs for the whole test; same pattern for pop.
  task automatic collect_results();
    int stall;
    res_t got;
    forever begin
      stall = rx_eager ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got.kind = kind;
      got.slot = slot;
      got.effect_id = effect_id;
      got.link_target = link_target;
      got.found = found;
      got.error_code = error_code;
      got.last = last;
      board.check_result(got);
    end
  endtask

  // Order load of random shape: clean permutation, one id too high, a
  // duplicate, too few or too many elements. Other commands may slip in
  // between elements; the load in progress must survive them.
  task automatic load_order();
    logic [7:0] elems[NE + 4];
    logic [7:0] t;
    int shape;
    int cnt;
    int p;
    int q;
    shape = $urandom_range(0, 4);
    cnt = NE;
    for (int i = 0; i < NE; i++) elems[i] = 8'(i);
    for (int i = NE - 1; i > 0; i--) begin
      p = $urandom_range(0, i);
      t = elems[i];
      elems[i] = elems[p];
      elems[p] = t;
    end
    p = $urandom_range(0, NE - 1);
    q = (p + $urandom_range(1, NE - 1)) % NE;
    case (shape)
      1: elems[p] = 8'($urandom_range(NE, 255));
      2: elems[q] = elems[p];
      3: cnt = $urandom_range(1, NE - 1);
      4: begin
        cnt = NE + $urandom_range(1, 4);
        for (int i = NE; i < cnt; i++) elems[i] = 8'($urandom_range(0, 255));
      end
      default: ;
    endcase
    for (int i = 0; i < cnt; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1))
          issue_cmd(OP_REPORT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        else
          issue_cmd(OP_SET_ENABLE, 8'($urandom_range(0, NE - 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      issue_cmd(OP_ELEMENT, elems[i], 1'($urandom_range(0, 1)), i == cnt - 1);
    end
  endtask

  task automatic random_cmd();
    int pick;
    logic [7:0] id;
    pick = $urandom_range(0, 99);
    // ids mostly inside the chain, sometimes anywhere in the byte
    id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                     : 8'($urandom_range(0, NE - 1));
    if (pick < 30)
      load_order();
    else if (pick < 42)
      issue_cmd(OP_REPORT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    else if (pick < 60)
      issue_cmd($urandom_range(0, 1) ? OP_MOVE_UP : OP_MOVE_DOWN, id,
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else if (pick < 88)
      issue_cmd(OP_SET_ENABLE, id, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else if (pick < 94)
      issue_cmd(OP_ELEMENT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    else
      issue_cmd(3'($urandom_range(OP_ELEMENT + 1, FUNC_CODES - 1)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
  endtask

  // result side starts once reset is released
  initial begin
    wait (!rst);
    collect_results();
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // identity order, nothing enabled: input/output with found 0, no links
    issue_cmd(OP_REPORT, 8'd0, 1'b0, 1'b0);
    // moves off either end of the chain change nothing
    issue_cmd(OP_MOVE_UP, 8'd0, 1'b0, 1'b0);
    issue_cmd(OP_MOVE_DOWN, 8'(NE - 1), 1'b1, 1'b1);
    // ids not in the chain
    issue_cmd(OP_MOVE_UP, 8'hFF, 1'b1, 1'b0);
    issue_cmd(OP_MOVE_DOWN, 8'(NE), 1'b0, 1'b1);
    // enables, including indexes past the chain that must be ignored
    issue_cmd(OP_SET_ENABLE, 8'd0, 1'b1, 1'b0);
    issue_cmd(OP_SET_ENABLE, 8'(NE - 1), 1'b1, 1'b1);
    issue_cmd(OP_SET_ENABLE, 8'hFF, 1'b1, 1'b0);
    issue_cmd(OP_SET_ENABLE, 8'(NE), 1'b1, 1'b0);
    issue_cmd(OP_SET_ENABLE, 8'd3, 1'b1, 1'b0);
    issue_cmd(OP_MOVE_UP, 8'd3, 1'b0, 1'b0);
    issue_cmd(OP_MOVE_DOWN, 8'd0, 1'b0, 1'b0);
    // unused func codes are swallowed without results
    for (int k = OP_ELEMENT + 1; k < FUNC_CODES; k++)
      issue_cmd(3'(k), 8'hFF, 1'b1, 1'b1);
    // short load with a report in the middle: wrong count
    issue_cmd(OP_ELEMENT, 8'd2, 1'b0, 1'b0);
    issue_cmd(OP_REPORT, 8'd0, 1'b0, 1'b0);
    issue_cmd(OP_ELEMENT, 8'd5, 1'b0, 1'b1);
    // clean load of the reversed order
    for (int i = 0; i < NE; i++)
      issue_cmd(OP_ELEMENT, 8'(NE - 1 - i), 1'b0, i == NE - 1);

    // --- random ---
    for (int phase = 0; n_cmds < 105; phase++) begin
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      repeat (8) random_cmd();
      // after the first phase, the sender holds off until every owed result has drained
      if (phase == 0 && board.due_results.size() != 0) begin
        push <= 1'b0;
        while (board.due_results.size() != 0) @(posedge clk);
      end
    end
    push <= 1'b0;

    // drain, then give the back end time to emit anything stray
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (4 * NE) @(posedge clk);
    if (board.due_results.size() != 0) begin
      board.errors++;
      $display("%0t: %0d results never arrived", $time, board.due_results.size());
    end

    $display("Ran %0d commands, checked %0d results field by field.",
             n_cmds, board.n_checked);
    $display("Order loads: %0d accepted, %0d rejected by the load check.",
             board.n_good_loads, board.n_bad_loads);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ecor_pkg.sv
hw/rtl/ecor_front.sv
hw/rtl/ecor_back.sv
hw/rtl/effect_chain_order_router.sv
verif/tb.sv
